// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define ASSERT_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- hdl/uer_pkg.sv -----
`timescale 1ns / 1ps

package uer_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int DELAY_W        = 8;
   localparam int CFG_CNT_W      = 24;
   localparam int ECHO_W         = 24;
   localparam int DIST_W         = 22;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_ECHO = CSR_INDEX_W'(3);

   localparam logic [DELAY_W-1:0]   SETTLE_RST   = DELAY_W'(2);
   localparam logic [DELAY_W-1:0]   TRIGGER_RST  = DELAY_W'(5);
   localparam logic [CFG_CNT_W-1:0] TIMEOUT_RST  = CFG_CNT_W'(1000000);
   localparam logic [CFG_CNT_W-1:0] MIN_ECHO_RST = CFG_CNT_W'(100);

   // distance = echo * 10 / 58 = (echo * 5) / 29
   localparam int NUM_W       = ECHO_W + 3;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 28;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam logic [NUM_W-1:0]   DIV_CONST = NUM_W'(29);
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd29);
   localparam logic [DIST_W-1:0]  DIST_MAX  = DIST_W'(2892623);

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_SETTLE    = 6'b000010,
      PH_TRIGGER   = 6'b000100,
      PH_WAIT_LOW  = 6'b001000,
      PH_WAIT_RISE = 6'b010000,
      PH_WAIT_FALL = 6'b100000
   } phase_type;

   typedef struct packed {
      logic drive_enable;
      logic drive_level;
      logic busy_res;
      logic done_res;
      logic timed_out;
   } flags_type;

endpackage

// ----- hdl/uer_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_ctrl import uer_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_pin_level,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   s1_valid,
   input  logic                   s1_stall,
   output flags_type              s1_flags,
   output logic [ECHO_W-1:0]      s1_echo
);

   localparam int CMP_W = (COUNT_BITS > CFG_CNT_W) ? COUNT_BITS : CFG_CNT_W;

   logic [DELAY_W-1:0]    settle_ff, trigger_ff;
   logic [CFG_CNT_W-1:0]  timeout_ff, min_echo_ff;

   phase_type             phase_ff, phase_in, shown;
   logic [DELAY_W-1:0]    delay_ff, delay_in, delay_inc;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in, elapsed_sat;
   logic [COUNT_BITS-1:0] pulse_ff, pulse_in, pulse_sat;
   logic [ECHO_W-1:0]     last_echo_ff, last_echo_in;
   logic                  done, tout, timeout_hit, pulse_long, accept;

   logic                  s1_valid_ff;
   flags_type             s1_flags_ff, flags_in;
   logic [ECHO_W-1:0]     s1_echo_ff;

   assign req_stall = s1_valid_ff && s1_stall;
   assign accept    = req_valid && !req_stall;

   assign delay_inc   = delay_ff + DELAY_W'(1);
   assign elapsed_sat = (&elapsed_ff) ? elapsed_ff : elapsed_ff + COUNT_BITS'(1);
   assign pulse_sat   = (&pulse_ff) ? pulse_ff : pulse_ff + COUNT_BITS'(1);
   assign timeout_hit = CMP_W'(elapsed_ff) >= CMP_W'(timeout_ff);
   assign pulse_long  = CMP_W'(pulse_sat) >= CMP_W'(min_echo_ff);

   always_comb begin
      phase_in     = phase_ff;
      delay_in     = delay_ff;
      elapsed_in   = elapsed_ff;
      pulse_in     = pulse_ff;
      last_echo_in = last_echo_ff;
      done         = 1'b0;
      tout         = 1'b0;
      if (req_kind) begin
         // starts while busy are dropped
         if (phase_ff == PH_IDLE) begin
            delay_in = '0;
            phase_in = (settle_ff == '0) ? PH_TRIGGER : PH_SETTLE;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_SETTLE: begin
               delay_in = delay_inc;
               if (delay_inc >= settle_ff) begin
                  phase_in = PH_TRIGGER;
                  delay_in = '0;
               end
            end
            PH_TRIGGER: begin
               delay_in = delay_inc;
               // a zero trigger setting ends after one tick
               if (delay_inc >= trigger_ff || delay_inc == '0) begin
                  phase_in   = PH_WAIT_LOW;
                  delay_in   = '0;
                  elapsed_in = '0;
               end
            end
            PH_WAIT_LOW, PH_WAIT_RISE, PH_WAIT_FALL: begin
               if (timeout_hit) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  tout     = 1'b1;
               end else begin
                  elapsed_in = elapsed_sat;
                  if (phase_ff == PH_WAIT_LOW) begin
                     if (!req_pin_level) phase_in = PH_WAIT_RISE;
                  end else if (phase_ff == PH_WAIT_RISE) begin
                     if (req_pin_level) begin
                        pulse_in = '0;
                        phase_in = PH_WAIT_FALL;
                     end
                  end else begin
                     pulse_in = pulse_sat;
                     if (!req_pin_level) begin
                        if (pulse_long) begin
                           last_echo_in = ECHO_W'(pulse_sat);
                           phase_in     = PH_IDLE;
                           done         = 1'b1;
                        end else begin
                           phase_in = PH_WAIT_RISE;
                        end
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // ticks show the pin during the tick, starts show the phase entered
   assign shown = req_kind ? phase_in : phase_ff;

   always_comb begin
      flags_in.drive_enable = (shown == PH_SETTLE) || (shown == PH_TRIGGER);
      flags_in.drive_level  = (shown == PH_TRIGGER);
      flags_in.busy_res     = (phase_in != PH_IDLE);
      flags_in.done_res     = done;
      flags_in.timed_out    = tout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff   <= SETTLE_RST;
         trigger_ff  <= TRIGGER_RST;
         timeout_ff  <= TIMEOUT_RST;
         min_echo_ff <= MIN_ECHO_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SETTLE:   settle_ff   <= csr_wdata[DELAY_W-1:0];
            CSR_TRIGGER:  trigger_ff  <= csr_wdata[DELAY_W-1:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata[CFG_CNT_W-1:0];
            CSR_MIN_ECHO: min_echo_ff <= csr_wdata[CFG_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         delay_ff     <= '0;
         elapsed_ff   <= '0;
         pulse_ff     <= '0;
         last_echo_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         delay_ff     <= delay_in;
         elapsed_ff   <= elapsed_in;
         pulse_ff     <= pulse_in;
         last_echo_ff <= last_echo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || !s1_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags_in;
         s1_echo_ff  <= last_echo_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_flags = s1_flags_ff;
   assign s1_echo  = s1_echo_ff;

   `ASSERT_CHK(a_tout_needs_done, clock, reset,
      s1_valid_ff && s1_flags_ff.timed_out |-> s1_flags_ff.done_res)
   `ASSERT_CHK(a_done_not_busy, clock, reset,
      s1_valid_ff && s1_flags_ff.done_res |-> !s1_flags_ff.busy_res)
   `ASSERT_CHK(a_level_needs_drive, clock, reset,
      s1_valid_ff && s1_flags_ff.drive_level |-> s1_flags_ff.drive_enable)
   `ASSERT_CHK(a_idle_tick_holds, clock, reset,
      accept && !req_kind && phase_ff == PH_IDLE |=> phase_ff == PH_IDLE)

endmodule

// ----- hdl/uer_dist.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_dist import uer_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  flags_type         in_flags,
   input  logic [ECHO_W-1:0] in_echo,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_drive_enable,
   output logic              rsp_drive_level,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic              rsp_timed_out,
   output logic [ECHO_W-1:0] rsp_echo_ticks,
   output logic [DIST_W-1:0] rsp_range_mm
);

   logic [NUM_W-1:0]  num, rem;
   logic [PROD_W-1:0] prod;
   logic [DIST_W-1:0] quot_fix;
   logic              a_ready;

   logic              a_valid_ff;
   flags_type         a_flags_ff;
   logic [ECHO_W-1:0] a_echo_ff;
   logic [NUM_W-1:0]  a_num_ff;
   logic [DIST_W-1:0] a_quot_ff;

   logic              rsp_valid_ff;
   flags_type         rsp_flags_ff;
   logic [ECHO_W-1:0] rsp_echo_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign a_ready  = !rsp_valid_ff || !rsp_stall;
   assign in_stall = a_valid_ff && !a_ready;

   // estimate by reciprocal, low by at most one
   assign num  = (NUM_W'(in_echo) << 2) + NUM_W'(in_echo);
   assign prod = num * DIV_RECIP;

   assign rem      = a_num_ff - NUM_W'(a_quot_ff) * DIV_CONST;
   assign quot_fix = (rem >= DIV_CONST) ? a_quot_ff + DIST_W'(1) : a_quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_valid_ff || a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         a_flags_ff <= in_flags;
         a_echo_ff  <= in_echo;
         a_num_ff   <= num;
         a_quot_ff  <= prod[RECIP_SHIFT +: DIST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_ready) begin
         rsp_flags_ff <= a_flags_ff;
         rsp_echo_ff  <= a_echo_ff;
         rsp_dist_ff  <= quot_fix;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_enable = rsp_flags_ff.drive_enable;
   assign rsp_drive_level  = rsp_flags_ff.drive_level;
   assign rsp_busy_res     = rsp_flags_ff.busy_res;
   assign rsp_done_res     = rsp_flags_ff.done_res;
   assign rsp_timed_out    = rsp_flags_ff.timed_out;
   assign rsp_echo_ticks   = rsp_echo_ff;
   assign rsp_range_mm     = rsp_dist_ff;

   `ASSERT_CHK(a_one_correction, clock, reset,
      a_valid_ff |-> rem < (DIV_CONST << 1))
   `ASSERT_CHK(a_dist_range, clock, reset,
      rsp_valid_ff |-> rsp_dist_ff <= DIST_MAX)
   `ASSERT_CHK(a_stall_when_full, clock, reset,
      in_stall |-> a_valid_ff && rsp_valid_ff)

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// a result passes the state, reciprocal and correction stages in order after its item is accepted
// throughput: one item per cycle while req_stall is low; req_stall rises only when all three stages hold items
// the distance path is a reciprocal multiply plus one remainder check, one stage each
// reset (synchronous, active high): phase idle, all counters and the last echo zero,
// registers back to settle 2, trigger 5, timeout 1000000, minimum echo 100; pipeline empty
`timescale 1ns / 1ps

module ultrasonic_echo_ranger import uer_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_pin_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_drive_enable,
   output logic                   rsp_drive_level,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_timed_out,
   output logic [ECHO_W-1:0]      rsp_echo_ticks,
   output logic [DIST_W-1:0]      rsp_range_mm,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic              s1_valid, s1_stall;
   flags_type         s1_flags;
   logic [ECHO_W-1:0] s1_echo;

   uer_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_pin_level (req_pin_level),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .s1_valid      (s1_valid),
      .s1_stall      (s1_stall),
      .s1_flags      (s1_flags),
      .s1_echo       (s1_echo)
   );

   uer_dist u_dist (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (s1_valid),
      .in_stall         (s1_stall),
      .in_flags         (s1_flags),
      .in_echo          (s1_echo),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_drive_level  (rsp_drive_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_timed_out    (rsp_timed_out),
      .rsp_echo_ticks   (rsp_echo_ticks),
      .rsp_range_mm     (rsp_range_mm)
   );

endmodule
